// ===== sv/ffde_pkg.sv =====
package ffde_pkg;

	localparam int ADDR_W = 16;
	localparam int SEQ_W  = 16;
	localparam int TTL_W  = 8;
	localparam int TICK_W = 32;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_ORIG = 2'd1,
		FUNC_RECV = 2'd2,
		FUNC_RSVD = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ACT_SEND    = 3'd0,
		ACT_FWD     = 3'd1,
		ACT_DELIVER = 3'd2,
		ACT_DUP     = 3'd3,
		ACT_TTL     = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		REG_MY_ADDR  = 3'd0,
		REG_BCAST    = 3'd1,
		REG_DEF_TTL  = 3'd2,
		REG_FLOOD    = 3'd3,
		REG_MAX_ENT  = 3'd4,
		REG_HOLD     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CO_HOLD   = 2'd0,
		CO_RIGHT  = 2'd1,
		CO_SORT   = 2'd2,
		CO_INSERT = 2'd3
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SORT,
		ST_EVICT,
		ST_INSERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] src;
		logic [SEQ_W-1:0]  seq;
		logic [TICK_W-1:0] expiry;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		logic     rot;    // last cell takes the checked head entry, else empty
		logic     odd;    // compaction phase
		logic     first;  // first beat of the walk
		logic     chk;    // look for a duplicate during the walk
	} ctrl_t;

	typedef struct packed {
		act_t              action;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dest;
		logic [SEQ_W-1:0]  seq;
		logic [TTL_W-1:0]  ttl;
		logic [TTL_W-1:0]  hop;
		logic              last;
	} res_t;

endpackage

// ===== sv/ffde_cell.sv =====
module ffde_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ffde_pkg::ctrl_t   ctrl,
	input  logic              is_left,
	input  logic              is_right,
	input  logic              sel_ins,
	input  ffde_pkg::entry_t  left_e,
	input  ffde_pkg::entry_t  right_e,
	input  ffde_pkg::entry_t  ins_e,
	output ffde_pkg::entry_t  e
);

	logic                          valid_q;
	logic [ffde_pkg::ADDR_W-1:0]   src_q;
	logic [ffde_pkg::SEQ_W-1:0]    seq_q;
	logic [ffde_pkg::TICK_W-1:0]   expiry_q;
	ffde_pkg::entry_t cur;
	ffde_pkg::entry_t e_d;

	always_comb begin
		cur.valid  = valid_q;
		cur.src    = src_q;
		cur.seq    = seq_q;
		cur.expiry = expiry_q;
	end

	always_comb begin
		e_d = cur;
		unique case (ctrl.op)
			ffde_pkg::CO_HOLD: e_d = cur;
			ffde_pkg::CO_RIGHT: e_d = right_e;
			ffde_pkg::CO_SORT: begin
				// move live entries toward the head, keeping their order
				if (is_left && !cur.valid && right_e.valid) begin
					e_d = right_e;
				end else if (is_right && !left_e.valid && cur.valid) begin
					e_d = left_e;
				end
			end
			ffde_pkg::CO_INSERT: begin
				if (sel_ins) begin
					e_d = ins_e;
				end
			end
			default: e_d = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= e_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		src_q    <= e_d.src;
		seq_q    <= e_d.seq;
		expiry_q <= e_d.expiry;
	end

	assign e = cur;

endmodule

// ===== sv/ffde_chain.sv =====
module ffde_chain #(
	parameter int TABLE_DEPTH = 32,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ffde_pkg::ctrl_t                ctrl,
	input  ffde_pkg::entry_t               key,
	input  logic [ffde_pkg::TICK_W-1:0]    now,
	output logic [CW-1:0]                  count,
	output logic                           found
);

	ffde_pkg::entry_t cells [TABLE_DEPTH];
	ffde_pkg::entry_t head_out;
	ffde_pkg::entry_t empty_e;
	ffde_pkg::entry_t tail_in;
	logic             live;
	logic             hit;
	logic             found_base;
	logic [CW-1:0]    count_base;
	logic [CW-1:0]    count_q;
	logic             found_q;

	always_comb begin
		empty_e = cells[0];
		empty_e.valid = 1'b0;
	end

	// expiry check and duplicate search on the entry leaving cell 0
	always_comb begin
		found_base = ctrl.first ? 1'b0 : found_q;
		count_base = ctrl.first ? '0 : count_q;
		live = cells[0].valid && !(cells[0].expiry < now);
		hit  = live && ctrl.chk && !found_base &&
			cells[0].src == key.src && cells[0].seq == key.seq;
		head_out = cells[0];
		head_out.valid = live;
		if (hit) begin
			head_out.expiry = key.expiry;
		end
		tail_in = ctrl.rot ? head_out : empty_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				ffde_pkg::CO_RIGHT: begin
					if (ctrl.rot) begin
						count_q <= count_base + CW'(live);
						found_q <= found_base | hit;
					end else begin
						count_q <= count_q - CW'(1);
					end
				end
				ffde_pkg::CO_INSERT: count_q <= count_q + CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ffde_pkg::entry_t left_e;
		ffde_pkg::entry_t right_e;
		logic             par_ok;

		assign left_e  = (i == 0) ? empty_e : cells[(i == 0) ? 0 : i - 1];
		assign right_e = (i == TABLE_DEPTH - 1) ? tail_in
			: cells[(i == TABLE_DEPTH - 1) ? i : i + 1];
		assign par_ok  = ((i % 2) == 1) == ctrl.odd;

		ffde_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.is_left  (par_ok && (i < TABLE_DEPTH - 1)),
			.is_right (!par_ok && (i > 0)),
			.sel_ins  (count_q == CW'(i)),
			.left_e   (left_e),
			.right_e  (right_e),
			.ins_e    (key),
			.e        (cells[i])
		);
	end

	assign count = count_q;
	assign found = found_q;

endmodule

// ===== sv/flood_forward_dedup_engine_core.sv =====
// Flooding node network layer with a duplicate suppression table held in a chain of
// TABLE_DEPTH cells, oldest entry at cell 0. A tick or an unknown function code is taken
// and gives no result. While plain_flooding is 0, originate and receive are accepted and
// then post their results. With plain_flooding set they are accepted, then the chain is
// rotated once through the expiry and match check at cell 0, then odd-even exchange steps
// pack the live entries toward cell 0, then the oldest entries are evicted one at a time
// until the count is below the limit, then the new entry is inserted and the results are
// posted. A received duplicate skips eviction and insert. Results sit in a two-beat output
// buffer and the next item is taken while they wait; an item posts its results only once
// the buffer is empty.
module flood_forward_dedup_engine_core #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // pkt_src, pkt_dest, pkt_seq, pkt_ttl
	input  logic [1:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_src, out_dest, out_seq, out_ttl, hop_count
	output logic [2:0]  m_axis_tuser,   // action
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(TABLE_DEPTH);

	// configuration
	logic [15:0] my_addr_q;
	logic [15:0] bcast_q;
	logic [7:0]  def_ttl_q;
	logic        flood_q;
	logic [5:0]  max_ent_q;
	logic [15:0] hold_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_addr_q <= 16'd0;
			bcast_q   <= 16'hffff;
			def_ttl_q <= 8'd5;
			flood_q   <= 1'b1;
			max_ent_q <= 6'd30;
			hold_q    <= 16'd3;
		end else if (wr_en) begin
			unique case (reg_idx)
				ffde_pkg::REG_MY_ADDR: my_addr_q <= pwdata[15:0];
				ffde_pkg::REG_BCAST:   bcast_q   <= pwdata[15:0];
				ffde_pkg::REG_DEF_TTL: def_ttl_q <= pwdata[7:0];
				ffde_pkg::REG_FLOOD:   flood_q   <= pwdata[0];
				ffde_pkg::REG_MAX_ENT: max_ent_q <= pwdata[5:0];
				ffde_pkg::REG_HOLD:    hold_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ffde_pkg::REG_MY_ADDR: prdata = {16'd0, my_addr_q};
			ffde_pkg::REG_BCAST:   prdata = {16'd0, bcast_q};
			ffde_pkg::REG_DEF_TTL: prdata = {24'd0, def_ttl_q};
			ffde_pkg::REG_FLOOD:   prdata = {31'd0, flood_q};
			ffde_pkg::REG_MAX_ENT: prdata = {26'd0, max_ent_q};
			ffde_pkg::REG_HOLD:    prdata = {16'd0, hold_q};
			default:               prdata = 32'd0;
		endcase
	end

	// state
	ffde_pkg::state_t state_q;
	ffde_pkg::state_t state_d;
	logic [SW-1:0]    step_q;
	logic [31:0]      now_q;
	logic [15:0]      next_seq_q;
	logic             orig_q;
	logic [15:0]      src_q;
	logic [15:0]      dest_q;
	logic [15:0]      seq_q;
	logic [7:0]       ttl_q;

	logic             in_beat;
	logic [1:0]       in_func;
	logic             step_end;
	logic [CW-1:0]    count;
	logic             found;
	logic [CW-1:0]    limit;
	logic             evict;
	logic [32:0]      exp_sum;
	ffde_pkg::entry_t key;
	ffde_pkg::ctrl_t  ctrl;
	logic             emit_load;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign in_func  = s_axis_tuser;
	assign step_end = step_q == SW'(TABLE_DEPTH - 1);

	always_comb begin
		if (max_ent_q == 6'd0) begin
			limit = CW'(1);
		end else if (32'(max_ent_q) > TABLE_DEPTH) begin
			limit = CW'(TABLE_DEPTH);
		end else begin
			limit = CW'(max_ent_q);
		end
	end

	assign evict   = (count >= limit) && (count != '0);
	assign exp_sum = {1'b0, now_q} + {17'd0, hold_q};

	always_comb begin
		key.valid  = 1'b1;
		key.src    = src_q;
		key.seq    = seq_q;
		key.expiry = exp_sum[32] ? 32'hffff_ffff : exp_sum[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffde_pkg::ST_IDLE: begin
				if (in_beat && (in_func == ffde_pkg::FUNC_ORIG ||
						in_func == ffde_pkg::FUNC_RECV)) begin
					state_d = flood_q ? ffde_pkg::ST_WALK : ffde_pkg::ST_EMIT;
				end
			end
			ffde_pkg::ST_WALK:   if (step_end) state_d = ffde_pkg::ST_SORT;
			ffde_pkg::ST_SORT: begin
				if (step_end) begin
					state_d = (!orig_q && found) ? ffde_pkg::ST_EMIT : ffde_pkg::ST_EVICT;
				end
			end
			ffde_pkg::ST_EVICT:  if (!evict) state_d = ffde_pkg::ST_INSERT;
			ffde_pkg::ST_INSERT: state_d = ffde_pkg::ST_EMIT;
			ffde_pkg::ST_EMIT:   if (emit_load) state_d = ffde_pkg::ST_IDLE;
			default:             state_d = ffde_pkg::ST_IDLE;
		endcase
	end

	logic [1:0] ocnt_q;

	// outputs of the sequencer
	always_comb begin
		ctrl       = '0;
		ctrl.op    = ffde_pkg::CO_HOLD;
		ctrl.odd   = step_q[0];
		ctrl.first = step_q == '0;
		ctrl.chk   = !orig_q;
		s_axis_tready = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			ffde_pkg::ST_IDLE: s_axis_tready = 1'b1;
			ffde_pkg::ST_WALK: begin
				ctrl.op  = ffde_pkg::CO_RIGHT;
				ctrl.rot = 1'b1;
			end
			ffde_pkg::ST_SORT:   ctrl.op = ffde_pkg::CO_SORT;
			ffde_pkg::ST_EVICT:  if (evict) ctrl.op = ffde_pkg::CO_RIGHT;
			ffde_pkg::ST_INSERT: ctrl.op = ffde_pkg::CO_INSERT;
			ffde_pkg::ST_EMIT:   emit_load = ocnt_q == 2'd0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ffde_pkg::ST_IDLE;
			step_q     <= '0;
			now_q      <= 32'd0;
			next_seq_q <= 16'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ffde_pkg::ST_WALK || state_q == ffde_pkg::ST_SORT) begin
				step_q <= step_end ? '0 : step_q + SW'(1);
			end
			if (in_beat && in_func == ffde_pkg::FUNC_TICK && now_q != 32'hffff_ffff) begin
				now_q <= now_q + 32'd1;
			end
			if (in_beat && in_func == ffde_pkg::FUNC_ORIG) begin
				next_seq_q <= next_seq_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			orig_q <= in_func == ffde_pkg::FUNC_ORIG;
			dest_q <= s_axis_tdata[31:16];
			ttl_q  <= s_axis_tdata[55:48];
			if (in_func == ffde_pkg::FUNC_ORIG) begin
				src_q <= my_addr_q;
				seq_q <= next_seq_q;
			end else begin
				src_q <= s_axis_tdata[15:0];
				seq_q <= s_axis_tdata[47:32];
			end
		end
	end

	ffde_chain #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CW          (CW)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.key    (key),
		.now    (now_q),
		.count  (count),
		.found  (found)
	);

	// result forming
	ffde_pkg::res_t r0;
	ffde_pkg::res_t r1;
	logic [1:0]     rn;
	logic [7:0]     ttl_dec;
	logic [7:0]     hop_keep;
	logic [7:0]     hop_dec;

	function automatic logic [7:0] hops(input logic [7:0] dflt, input logic [7:0] t);
		logic [9:0] d;
		d = {2'b00, dflt} + 10'd1 - {2'b00, t};
		if (d[9]) begin
			return 8'd0;
		end else if (d[8]) begin
			return 8'hff;
		end
		return d[7:0];
	endfunction

	assign ttl_dec  = ttl_q - 8'd1;
	assign hop_keep = hops(def_ttl_q, ttl_q);
	assign hop_dec  = hops(def_ttl_q, ttl_dec);

	always_comb begin
		r0.src  = src_q;
		r0.dest = dest_q;
		r0.seq  = seq_q;
		r0.ttl  = ttl_q;
		r0.hop  = 8'd0;
		r0.last = 1'b1;
		r0.action = ffde_pkg::ACT_TTL;
		r1 = r0;
		r1.action = ffde_pkg::ACT_DELIVER;
		r1.ttl = ttl_dec;
		r1.hop = hop_dec;
		rn = 2'd1;
		if (orig_q) begin
			r0.action = ffde_pkg::ACT_SEND;
			r0.ttl    = def_ttl_q;
		end else if (flood_q && found) begin
			r0.action = ffde_pkg::ACT_DUP;
		end else if (dest_q == my_addr_q) begin
			r0.action = ffde_pkg::ACT_DELIVER;
			r0.hop    = hop_keep;
		end else if (dest_q == bcast_q) begin
			if (ttl_q > 8'd1) begin
				r0.action = ffde_pkg::ACT_FWD;
				r0.ttl    = ttl_dec;
				r0.last   = 1'b0;
				rn        = 2'd2;
			end else begin
				r0.action = ffde_pkg::ACT_DELIVER;
				r0.hop    = hop_keep;
			end
		end else if (ttl_q > 8'd1) begin
			r0.action = ffde_pkg::ACT_FWD;
			r0.ttl    = ttl_dec;
		end
	end

	// two-beat output buffer
	ffde_pkg::res_t slot0_q;
	ffde_pkg::res_t slot1_q;
	logic           out_beat;

	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else if (emit_load) begin
			ocnt_q <= rn;
		end else if (out_beat) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (out_beat) begin
			slot0_q <= slot1_q;
		end
	end

	assign m_axis_tvalid = ocnt_q != 2'd0;
	assign m_axis_tdata  = {slot0_q.hop, slot0_q.ttl, slot0_q.seq, slot0_q.dest, slot0_q.src};
	assign m_axis_tuser  = slot0_q.action;
	assign m_axis_tlast  = slot0_q.last;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;   // pkt_src, pkt_dest, pkt_seq, pkt_ttl
	logic [1:0]  s_axis_tuser;   // func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // out_src, out_dest, out_seq, out_ttl, hop_count
	logic [2:0]  m_axis_tuser;   // action
	logic        m_axis_tlast;

	flood_forward_dedup_engine_core dut (.*);

	// node model
	logic [15:0] node_addr, bcast_addr, hold_cfg;
	logic [7:0]  ttl_cfg;
	logic        flood_on;
	logic [5:0]  max_cfg;
	logic [31:0] tick_now;
	logic [15:0] seq_next;
	logic [15:0] seen_src[$];
	logic [15:0] seen_seq[$];
	logic [31:0] seen_exp[$];
	ffde_pkg::res_t pending[$];

	int errors;
	int cycles;
	int send_idle, recv_idle;
	bit recv_hold;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic [31:0] expiry_now();
		logic [32:0] e;
		e = {1'b0, tick_now} + {17'd0, hold_cfg};
		return e[32] ? 32'hffffffff : e[31:0];
	endfunction

	function automatic logic [7:0] hops(logic [7:0] t);
		int d;
		d = int'(ttl_cfg) + 1 - int'(t);
		return d < 0 ? 8'd0 : (d > 255 ? 8'd255 : 8'(d));
	endfunction

	function automatic void purge_seen();
		for (int i = seen_exp.size() - 1; i >= 0; i--)
			if (seen_exp[i] < tick_now) begin
				seen_src.delete(i);
				seen_seq.delete(i);
				seen_exp.delete(i);
			end
	endfunction

	function automatic void record_seen(logic [15:0] s, logic [15:0] q);
		int lim;
		lim = max_cfg < 1 ? 1 : (max_cfg > DEPTH ? DEPTH : int'(max_cfg));
		while (seen_src.size() >= lim) begin
			seen_src.delete(0);
			seen_seq.delete(0);
			seen_exp.delete(0);
		end
		seen_src = {seen_src, s};
		seen_seq = {seen_seq, q};
		seen_exp = {seen_exp, expiry_now()};
	endfunction

	function automatic void push_res(ffde_pkg::act_t a, logic [15:0] s, logic [15:0] d,
			logic [15:0] q, logic [7:0] t, logic [7:0] h, logic l);
		ffde_pkg::res_t r;
		r.action = a; r.src = s; r.dest = d; r.seq = q; r.ttl = t; r.hop = h; r.last = l;
		pending = {pending, r};
	endfunction

	function automatic void predict_node(logic [1:0] fn, logic [15:0] s, logic [15:0] d,
			logic [15:0] q, logic [7:0] t);
		if (fn == ffde_pkg::FUNC_TICK) begin
			if (tick_now != 32'hffffffff) tick_now++;
			return;
		end
		if (fn == ffde_pkg::FUNC_ORIG) begin
			if (flood_on) begin
				purge_seen();
				record_seen(node_addr, seq_next);
			end
			push_res(ffde_pkg::ACT_SEND, node_addr, d, seq_next, ttl_cfg, 8'd0, 1'b1);
			seq_next++;
			return;
		end
		if (fn != ffde_pkg::FUNC_RECV) return;
		if (flood_on) begin
			purge_seen();
			foreach (seen_src[i])
				if (seen_src[i] == s && seen_seq[i] == q) begin
					seen_exp[i] = expiry_now();
					push_res(ffde_pkg::ACT_DUP, s, d, q, t, 8'd0, 1'b1);
					return;
				end
			record_seen(s, q);
		end
		if (d == node_addr)
			push_res(ffde_pkg::ACT_DELIVER, s, d, q, t, hops(t), 1'b1);
		else if (d == bcast_addr) begin
			if (t > 1) begin
				push_res(ffde_pkg::ACT_FWD, s, d, q, t - 8'd1, 8'd0, 1'b0);
				push_res(ffde_pkg::ACT_DELIVER, s, d, q, t - 8'd1, hops(t - 8'd1), 1'b1);
			end else
				push_res(ffde_pkg::ACT_DELIVER, s, d, q, t, hops(t), 1'b1);
		end else if (t > 1)
			push_res(ffde_pkg::ACT_FWD, s, d, q, t - 8'd1, 8'd0, 1'b1);
		else
			push_res(ffde_pkg::ACT_TTL, s, d, q, t, 8'd0, 1'b1);
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected result tdata=%h user=%0d", $time, m_axis_tdata,
					m_axis_tuser);
				errors++;
			end else begin
				ffde_pkg::res_t e;
				e = pending[0];
				pending.delete(0);
				if (m_axis_tuser !== e.action || m_axis_tlast !== e.last
						|| m_axis_tdata !== {e.hop, e.ttl, e.seq, e.dest, e.src}) begin
					$display("%0t mismatch expected act=%0d data=%h last=%0d actual act=%0d data=%h last=%0d",
						$time, e.action, {e.hop, e.ttl, e.seq, e.dest, e.src}, e.last,
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
					errors++;
				end
			end
		end
		m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
	end

	task automatic cfg_write(ffde_pkg::reg_idx_t idx, logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= 5'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			ffde_pkg::REG_MY_ADDR: node_addr = val[15:0];
			ffde_pkg::REG_BCAST:   bcast_addr = val[15:0];
			ffde_pkg::REG_DEF_TTL: ttl_cfg = val[7:0];
			ffde_pkg::REG_FLOOD:   flood_on = val[0];
			ffde_pkg::REG_MAX_ENT: max_cfg = val[5:0];
			ffde_pkg::REG_HOLD:    hold_cfg = val[15:0];
			default: ;
		endcase
	endtask

	task automatic send_item(logic [1:0] fn, logic [15:0] s, logic [15:0] d,
			logic [15:0] q, logic [7:0] t);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {t, q, d, s};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_node(fn, s, d, q, t);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(ffde_pkg::FUNC_ORIG, 0, 16'hffff, 0, 0);
		send_item(ffde_pkg::FUNC_RECV, 0, 16'h1234, 0, 8'd9);      // own originated: duplicate
		send_item(ffde_pkg::FUNC_RECV, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		send_item(ffde_pkg::FUNC_RECV, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		send_item(ffde_pkg::FUNC_RECV, 16'h0001, 16'h0000, 16'h0001, 8'd0);
		send_item(ffde_pkg::FUNC_RECV, 16'h0002, 16'hffff, 16'h0002, 8'd1);
		send_item(ffde_pkg::FUNC_RECV, 16'h0003, 16'h5555, 16'h0003, 8'd1);
		send_item(ffde_pkg::FUNC_RECV, 16'h0004, 16'haaaa, 16'h0004, 8'd2);
		send_item(ffde_pkg::FUNC_RSVD, 16'h0004, 16'haaaa, 16'h0004, 8'd2);
		repeat (5) send_item(ffde_pkg::FUNC_TICK, 0, 0, 0, 0);
		send_item(ffde_pkg::FUNC_RECV, 16'hffff, 16'hffff, 16'hffff, 8'hff); // expired, seen fresh
		drain();
		cfg_write(ffde_pkg::REG_MY_ADDR, 16'h0042);
		cfg_write(ffde_pkg::REG_BCAST, 16'h0042);
		cfg_write(ffde_pkg::REG_DEF_TTL, 255);
		send_item(ffde_pkg::FUNC_RECV, 16'h0010, 16'h0042, 16'h0010, 8'd0);
		send_item(ffde_pkg::FUNC_RECV, 16'h0011, 16'h0042, 16'h0011, 8'd255);
		drain();
		cfg_write(ffde_pkg::REG_DEF_TTL, 1);
		send_item(ffde_pkg::FUNC_ORIG, 0, 16'h0042, 0, 0);
		send_item(ffde_pkg::FUNC_RECV, 16'h0012, 16'h0042, 16'h0012, 8'd255);
		drain();
	endtask

	task automatic test_random(int n, int span, int ttl_top);
		logic [15:0] s, q;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			s = 16'($urandom_range(span)); q = 16'($urandom_range(span));
			if (r < 4) begin
				s = 16'($urandom); q = 16'($urandom);
			end
			if (r < 15)
				send_item(ffde_pkg::FUNC_TICK, 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			else if (r < 30)
				send_item(ffde_pkg::FUNC_ORIG, 16'($urandom),
					r[0] ? bcast_addr : 16'($urandom), 16'd0, 8'd0);
			else if (r < 32)
				send_item(ffde_pkg::FUNC_RSVD, 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			else
				send_item(ffde_pkg::FUNC_RECV, s,
					r[1:0] == 0 ? node_addr : (r[1:0] == 1 ? bcast_addr : 16'($urandom)),
					q, r[2] ? 8'($urandom) : 8'($urandom_range(ttl_top)));
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1;
				repeat (800) @(posedge clk);
				recv_hold = 0;
			end
			test_random(20, 7, 3);
		join
		drain();
	endtask

	task automatic test_settings();
		cfg_write(ffde_pkg::REG_MY_ADDR, 16'h0005);
		cfg_write(ffde_pkg::REG_BCAST, 16'hffff);
		cfg_write(ffde_pkg::REG_DEF_TTL, 5);
		cfg_write(ffde_pkg::REG_FLOOD, 1);
		cfg_write(ffde_pkg::REG_MAX_ENT, 1);
		cfg_write(ffde_pkg::REG_HOLD, 0);
		send_idle = 25; recv_idle = 85;
		test_random(200, 7, 4);
		drain();
		cfg_write(ffde_pkg::REG_MAX_ENT, 32);
		cfg_write(ffde_pkg::REG_HOLD, 65535);
		send_idle = 85; recv_idle = 25;
		test_random(250, 40, 4);
		drain();
		cfg_write(ffde_pkg::REG_MAX_ENT, 0);
		cfg_write(ffde_pkg::REG_HOLD, 2);
		cfg_write(ffde_pkg::REG_DEF_TTL, 128);
		send_idle = 0; recv_idle = 0;
		test_random(250, 15, 255);
		drain();
		cfg_write(ffde_pkg::REG_MAX_ENT, 63);
		cfg_write(ffde_pkg::REG_HOLD, 7);
		test_random(250, 63, 6);
		drain();
		cfg_write(ffde_pkg::REG_FLOOD, 0);
		cfg_write(ffde_pkg::REG_MY_ADDR, 16'hffff);
		cfg_write(ffde_pkg::REG_BCAST, 16'h0000);
		test_random(150, 7, 3);
		drain();
		cfg_write(ffde_pkg::REG_MY_ADDR, 16'h0003);
		cfg_write(ffde_pkg::REG_FLOOD, 1);
		cfg_write(ffde_pkg::REG_MAX_ENT, 8);
		test_random(200, 20, 5);
		drain();
	endtask

	initial begin
		send_idle = 0; recv_idle = 0; recv_hold = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
		node_addr = 0; bcast_addr = 16'hffff; ttl_cfg = 5; flood_on = 1;
		max_cfg = 30; hold_cfg = 3; tick_now = 0; seq_next = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		test_directed();
		test_backpressure();
		test_settings();
		drain();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== files.f =====
sv/ffde_pkg.sv
sv/ffde_cell.sv
sv/ffde_chain.sv
sv/flood_forward_dedup_engine_core.sv
tb/sv/tb.sv
